[src/ufv_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ufv_pkg;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned CRC_W      = 16;
	localparam int unsigned LEN_W      = 16;
	localparam int unsigned FLEN_W     = 17;
	localparam int unsigned ROLE_W     = 4;
	localparam int unsigned CFG_IDX_W  = 8;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CRC_W-1:0] CRC_POLY = 16'h8408;
	localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
	localparam logic [CRC_W-1:0] CRC_XOR  = 16'hFFFF;

	// Fixed frame bytes: two start, version, type, srctype, srclen, cmd,
	// two length bytes and two CRC bytes.
	localparam logic [FLEN_W-1:0] FIXED_BYTES = 17'd11;

	localparam logic [CFG_IDX_W-1:0] REG_START_ONE   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_TWO   = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SRC_LEN = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PAY_LEN = 8'd3;

	localparam logic [BYTE_W-1:0] RST_START_ONE   = 8'hAA;
	localparam logic [BYTE_W-1:0] RST_START_TWO   = 8'h55;
	localparam logic [BYTE_W-1:0] RST_MAX_SRC_LEN = 8'd32;
	localparam logic [LEN_W-1:0]  RST_MAX_PAY_LEN = 16'd1024;

	localparam logic [ROLE_W-1:0] ROLE_CRC = 4'd11;

	typedef enum logic [3:0] {
		PH_SOF1    = 4'd0,
		PH_SOF2    = 4'd1,
		PH_VER     = 4'd2,
		PH_TYPE    = 4'd3,
		PH_SRCTYPE = 4'd4,
		PH_SRCLEN  = 4'd5,
		PH_ADDR    = 4'd6,
		PH_CMD     = 4'd7,
		PH_LENH    = 4'd8,
		PH_LENL    = 4'd9,
		PH_PAYLOAD = 4'd10,
		PH_CRCH    = 4'd11,
		PH_CRCL    = 4'd12
	} phase_t;

	typedef enum logic [1:0] {
		ST_MORE     = 2'd0,
		ST_BAD      = 2'd1,
		ST_COMPLETE = 2'd2
	} status_t;

	typedef struct packed {
		logic [BYTE_W-1:0] start_one;
		logic [BYTE_W-1:0] start_two;
		logic [BYTE_W-1:0] max_src_len;
		logic [LEN_W-1:0]  max_pay_len;
	} cfg_t;

	typedef struct packed {
		status_t            status;
		logic [ROLE_W-1:0]  role;
		logic [FLEN_W-1:0]  flen;
		logic [BYTE_W-1:0]  cmd;
	} res_t;

	// Reflected CRC-16 update, one byte.
	function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
			input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

[src/ufv_cfg_regs.sv]
`timescale 1ns / 1ps
`default_nettype none

module ufv_cfg_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [ufv_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [ufv_pkg::CFG_DATA_W-1:0]  cfg_data,
	output ufv_pkg::cfg_t                        cfg
);
	import ufv_pkg::*;

	cfg_t cfg_q;

	// Writes to an index past the last register are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_one   <= RST_START_ONE;
			cfg_q.start_two   <= RST_START_TWO;
			cfg_q.max_src_len <= RST_MAX_SRC_LEN;
			cfg_q.max_pay_len <= RST_MAX_PAY_LEN;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START_ONE:   cfg_q.start_one   <= cfg_data[BYTE_W-1:0];
				REG_START_TWO:   cfg_q.start_two   <= cfg_data[BYTE_W-1:0];
				REG_MAX_SRC_LEN: cfg_q.max_src_len <= cfg_data[BYTE_W-1:0];
				REG_MAX_PAY_LEN: cfg_q.max_pay_len <= cfg_data[LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[src/ufv_parser.sv]
`timescale 1ns / 1ps
`default_nettype none

module ufv_parser (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        step_en,
	input  wire logic [ufv_pkg::BYTE_W-1:0]  rx_byte,
	input  ufv_pkg::cfg_t                    cfg,
	output ufv_pkg::res_t                    res
);
	import ufv_pkg::*;

	phase_t             phase_q, phase_d;
	logic [LEN_W-1:0]   pos_q, pos_d;
	logic [CRC_W-1:0]   crc_q, crc_d;
	logic [BYTE_W-1:0]  src_len_q, src_len_d;
	logic [LEN_W-1:0]   pay_len_q, pay_len_d;
	logic [BYTE_W-1:0]  cmd_q, cmd_d;
	logic [BYTE_W-1:0]  crc_hi_q, crc_hi_d;

	logic [CRC_W-1:0]   crc_fed;
	logic [LEN_W-1:0]   pos_inc;
	logic [LEN_W-1:0]   pay_len_full;
	logic [CRC_W-1:0]   crc_rx;
	status_t            status;

	assign crc_fed      = crc_feed(crc_q, rx_byte);
	assign pos_inc      = pos_q + 16'd1;
	assign pay_len_full = {pay_len_q[LEN_W-1:BYTE_W], rx_byte};
	assign crc_rx       = {crc_hi_q, rx_byte};

	// Outputs: verdict and result fields for the byte at hand.
	always_comb begin
		status   = ST_MORE;
		res.role = (phase_q > PH_CRCH) ? ROLE_CRC : ROLE_W'(phase_q);
		res.flen = '0;
		res.cmd  = '0;
		case (phase_q)
			PH_SOF1: begin
				if (rx_byte != cfg.start_one) status = ST_BAD;
			end
			PH_SOF2: begin
				if (rx_byte != cfg.start_two) status = ST_BAD;
			end
			PH_SRCLEN: begin
				if (rx_byte > cfg.max_src_len) status = ST_BAD;
			end
			PH_LENL: begin
				if (pay_len_full > cfg.max_pay_len) status = ST_BAD;
			end
			PH_CRCL: begin
				if (crc_rx == (crc_q ^ CRC_XOR)) begin
					status   = ST_COMPLETE;
					res.flen = FIXED_BYTES + FLEN_W'(src_len_q) + FLEN_W'(pay_len_q);
					res.cmd  = cmd_q;
				end else begin
					status = ST_BAD;
				end
			end
			PH_VER, PH_TYPE, PH_SRCTYPE, PH_ADDR, PH_CMD, PH_LENH, PH_PAYLOAD,
			PH_CRCH: begin
			end
			default: status = ST_BAD;
		endcase
		res.status = status;
	end

	// Next state.
	always_comb begin
		phase_d   = phase_q;
		pos_d     = pos_q;
		crc_d     = crc_q;
		src_len_d = src_len_q;
		pay_len_d = pay_len_q;
		cmd_d     = cmd_q;
		crc_hi_d  = crc_hi_q;
		if (phase_q >= PH_VER && phase_q <= PH_PAYLOAD) crc_d = crc_fed;
		case (phase_q)
			PH_SOF1:    phase_d = PH_SOF2;
			PH_SOF2:    phase_d = PH_VER;
			PH_VER:     phase_d = PH_TYPE;
			PH_TYPE:    phase_d = PH_SRCTYPE;
			PH_SRCTYPE: phase_d = PH_SRCLEN;
			PH_SRCLEN: begin
				src_len_d = rx_byte;
				pos_d     = '0;
				phase_d   = (rx_byte == '0) ? PH_CMD : PH_ADDR;
			end
			PH_ADDR: begin
				pos_d = pos_inc;
				if (pos_inc >= LEN_W'(src_len_q)) phase_d = PH_CMD;
			end
			PH_CMD: begin
				cmd_d   = rx_byte;
				phase_d = PH_LENH;
			end
			PH_LENH: begin
				pay_len_d = {rx_byte, 8'h00};
				phase_d   = PH_LENL;
			end
			PH_LENL: begin
				pay_len_d = pay_len_full;
				pos_d     = '0;
				phase_d   = (pay_len_full == '0) ? PH_CRCH : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				pos_d = pos_inc;
				if (pos_inc >= pay_len_q) phase_d = PH_CRCH;
			end
			PH_CRCH: begin
				crc_hi_d = rx_byte;
				phase_d  = PH_CRCL;
			end
			default: phase_d = PH_SOF1;
		endcase
		// Drop back to the hunt after any verdict.
		if (status != ST_MORE) begin
			phase_d   = PH_SOF1;
			pos_d     = '0;
			crc_d     = CRC_INIT;
			src_len_d = '0;
			pay_len_d = '0;
			cmd_d     = '0;
			crc_hi_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SOF1;
			pos_q     <= '0;
			crc_q     <= CRC_INIT;
			src_len_q <= '0;
			pay_len_q <= '0;
			cmd_q     <= '0;
			crc_hi_q  <= '0;
		end else if (step_en) begin
			phase_q   <= phase_d;
			pos_q     <= pos_d;
			crc_q     <= crc_d;
			src_len_q <= src_len_d;
			pay_len_q <= pay_len_d;
			cmd_q     <= cmd_d;
			crc_hi_q  <= crc_hi_d;
		end
	end

	a_hunt_crc_init: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SOF1 |-> crc_q == CRC_INIT && pos_q == '0)
		else $error("CRC or position not cleared while hunting");

endmodule

`default_nettype wire

[src/uart_frame_validator_crc16_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Byte-stream frame validator with CRC-16/X.25 check. Each byte taken on the
// input channel yields exactly one result request: status need-more, bad or
// complete, the role of that byte in the frame, and on complete the total
// frame length and command byte (both zero otherwise). The frame is two
// start bytes, version, type, source type, source length, source address,
// command, big-endian payload length, payload and big-endian CRC; the CRC
// covers version through the last payload byte. On a bad start byte, an
// oversized source or payload length, or a CRC mismatch the block reports
// bad and returns to hunting for the first start byte; the offending byte
// is consumed. Throughput is one byte per clock while the result channel
// does not stall: the parser does a full byte-wide CRC update and the frame
// step combinationally between the input register and the result register.
// Configuration registers (start bytes, length limits) are written through
// the plain write port; the user must write them only while no request is
// in flight, as the block itself does not enforce this. Writes to an index
// above the last register are ignored.
module uart_frame_validator_crc16_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration write port
	input  wire logic                            cfg_we,
	input  wire logic [ufv_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [ufv_pkg::CFG_DATA_W-1:0]  cfg_data,
	// byte input channel
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [ufv_pkg::BYTE_W-1:0]      rx_byte,
	// result channel
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [1:0]                           status,
	output logic [ufv_pkg::ROLE_W-1:0]           byte_role,
	output logic [ufv_pkg::FLEN_W-1:0]           frame_length,
	output logic [ufv_pkg::BYTE_W-1:0]           command
);
	import ufv_pkg::*;

	cfg_t               cfg;
	res_t               res;

	logic               valid_s1;
	logic [BYTE_W-1:0]  byte_s1;
	logic               valid_s2;
	res_t               res_s2;

	logic               in_fire;
	logic               advance;

	// Advance the input register into the result register whenever the
	// result slot is empty or being drained this cycle.
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_fire  = in_valid && !in_stall;

	ufv_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Frame tracker: steps its state only when a byte moves to the result.
	ufv_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.rx_byte (byte_s1),
		.cfg     (cfg),
		.res     (res)
	);

	// Input register: hold while stalled, load on accept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_fire || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) byte_s1 <= rx_byte;
	end

	// Result register: hold while the consumer stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= advance || (valid_s2 && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) res_s2 <= res;
	end

	assign out_valid    = valid_s2;
	assign status       = res_s2.status;
	assign byte_role    = res_s2.role;
	assign frame_length = res_s2.flen;
	assign command      = res_s2.cmd;

	a_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.status != ST_COMPLETE |-> res_s2.flen == '0 && res_s2.cmd == '0)
		else $error("length or command set without a complete frame");

	a_complete_on_crc: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.status == ST_COMPLETE |-> res_s2.role == ROLE_CRC)
		else $error("frame completed on a byte that is not a CRC byte");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && out_stall |-> !advance)
		else $error("result register advanced over a stalled result");

	a_in_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("input stalled without downstream back-pressure");

endmodule

`default_nettype wire

[tb/uart_frame_validator_crc16_core_tb.sv]
`timescale 1ns / 1ps

module uart_frame_validator_crc16_core_tb;

	import ufv_pkg::*;

	// Clock, reset and every block input start at known values.
	logic                  clk = 1'b1;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [BYTE_W-1:0]     rx_byte = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [1:0]            status;
	logic [ROLE_W-1:0]     byte_role;
	logic [FLEN_W-1:0]     frame_length;
	logic [BYTE_W-1:0]     command;

	// Percentage of cycles in which each side idles; zero gives a clean stretch.
	int   idle_pct = 26;
	// Long receiver hold-off, raised and dropped by the backpressure test.
	logic hold_off = 1'b0;
	int   error_count = 0;
	int   bytes_sent = 0;
	int   verdict_count = 0;

	// Register shadow, kept in step with every write the bench issues.
	cfg_t shadow_cfg = '{start_one: RST_START_ONE, start_two: RST_START_TWO,
		max_src_len: RST_MAX_SRC_LEN, max_pay_len: RST_MAX_PAY_LEN};

	// Parser state of the prediction: where in the frame the next byte lands.
	phase_t           pr_phase;
	logic [LEN_W-1:0] pr_count;
	logic [CRC_W-1:0] pr_crc;
	logic [7:0]       pr_src_len;
	logic [LEN_W-1:0] pr_pay_len;
	logic [7:0]       pr_cmd;
	logic [7:0]       pr_crc_hi;

	// One verdict per accepted byte, oldest first.
	res_t pending_verdicts[$];

	uart_frame_validator_crc16_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.byte_role    (byte_role),
		.frame_length (frame_length),
		.command      (command)
	);

	always begin
		#2 clk = 1'b0;
		#2 clk = 1'b1;
	end

	// Hard stop in case a request never completes.
	initial begin
		#8_000_000;
		$display("uart_frame_validator_crc16_core regression: fail");
		$finish;
	end

	task automatic flag_error(input string msg);
		$display("%0t ERROR verdict %0d: %s", $time, verdict_count, msg);
		error_count++;
	endtask

	// CRC-16/X.25 register update, one data bit at a time, LSB first.
	function automatic logic [CRC_W-1:0] x25_update(input logic [CRC_W-1:0] crc,
			input logic [7:0] b);
		logic [CRC_W-1:0] c;
		logic             fb;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c = c >> 1;
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	// Drop back to hunting for the first start byte.
	function automatic void clear_parser();
		pr_phase   = PH_SOF1;
		pr_count   = '0;
		pr_crc     = CRC_INIT;
		pr_src_len = '0;
		pr_pay_len = '0;
		pr_cmd     = '0;
		pr_crc_hi  = '0;
	endfunction

	// Advance the predicted parser by one accepted byte and queue its verdict.
	function automatic void parse_rx_byte(input logic [7:0] b);
		res_t             v;
		logic [CRC_W-1:0] rx_crc;
		v.status = ST_MORE;
		v.role   = (pr_phase > PH_CRCH) ? ROLE_CRC : ROLE_W'(pr_phase);
		v.flen   = '0;
		v.cmd    = '0;
		// Version through last payload byte feed the CRC.
		if (pr_phase >= PH_VER && pr_phase <= PH_PAYLOAD) begin
			pr_crc = x25_update(pr_crc, b);
		end
		case (pr_phase)
			PH_SOF1: begin
				if (b == shadow_cfg.start_one) pr_phase = PH_SOF2;
				else v.status = ST_BAD;
			end
			PH_SOF2: begin
				if (b == shadow_cfg.start_two) pr_phase = PH_VER;
				else v.status = ST_BAD;
			end
			PH_VER:     pr_phase = PH_TYPE;
			PH_TYPE:    pr_phase = PH_SRCTYPE;
			PH_SRCTYPE: pr_phase = PH_SRCLEN;
			PH_SRCLEN: begin
				if (b > shadow_cfg.max_src_len) begin
					v.status = ST_BAD;
				end else begin
					pr_src_len = b;
					pr_count   = '0;
					pr_phase   = (b == 8'd0) ? PH_CMD : PH_ADDR;
				end
			end
			PH_ADDR: begin
				pr_count = pr_count + 1'b1;
				if (pr_count >= {8'd0, pr_src_len}) pr_phase = PH_CMD;
			end
			PH_CMD: begin
				pr_cmd   = b;
				pr_phase = PH_LENH;
			end
			PH_LENH: begin
				pr_pay_len = {b, 8'd0};
				pr_phase   = PH_LENL;
			end
			PH_LENL: begin
				pr_pay_len = {pr_pay_len[15:8], b};
				if (pr_pay_len > shadow_cfg.max_pay_len) begin
					v.status = ST_BAD;
				end else begin
					pr_count = '0;
					pr_phase = (pr_pay_len == '0) ? PH_CRCH : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				pr_count = pr_count + 1'b1;
				if (pr_count >= pr_pay_len) pr_phase = PH_CRCH;
			end
			PH_CRCH: begin
				pr_crc_hi = b;
				pr_phase  = PH_CRCL;
			end
			default: begin
				// Received CRC is big-endian; compare against the finished CRC.
				rx_crc = {pr_crc_hi, b};
				if (pr_phase == PH_CRCL && rx_crc == (pr_crc ^ CRC_XOR)) begin
					v.status = ST_COMPLETE;
					v.flen   = FIXED_BYTES + FLEN_W'(pr_src_len) + FLEN_W'(pr_pay_len);
					v.cmd    = pr_cmd;
				end else begin
					v.status = ST_BAD;
				end
			end
		endcase
		if (v.status != ST_MORE) begin
			clear_parser();
		end
		pending_verdicts.push_back(v);
	endfunction

	initial clear_parser();

	// Compare one taken result request against the oldest pending verdict.
	task automatic check_verdict();
		res_t want;
		verdict_count++;
		if (pending_verdicts.size() == 0) begin
			flag_error($sformatf("unexpected result status %0d role %0d", status, byte_role));
			return;
		end
		want = pending_verdicts.pop_front();
		if (status !== want.status)
			flag_error($sformatf("status got %0d want %0d", status, want.status));
		if (byte_role !== want.role)
			flag_error($sformatf("byte_role got %0d want %0d", byte_role, want.role));
		if (frame_length !== want.flen)
			flag_error($sformatf("frame_length got %0d want %0d", frame_length, want.flen));
		if (command !== want.cmd)
			flag_error($sformatf("command got %0h want %0h", command, want.cmd));
	endtask

	// Result side: take the request seen at this edge, then pick the next stall.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			check_verdict();
		end
		out_stall <= hold_off || ($urandom_range(99) < idle_pct);
	end

	// Offer one byte, idling at random first; leave valid high after the take.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		parse_rx_byte(b);
		bytes_sent++;
	endtask

	// Register write; only issued while nothing is in flight.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_START_ONE:   shadow_cfg.start_one   = data[7:0];
			REG_START_TWO:   shadow_cfg.start_two   = data[7:0];
			REG_MAX_SRC_LEN: shadow_cfg.max_src_len = data[7:0];
			REG_MAX_PAY_LEN: shadow_cfg.max_pay_len = data;
			default: ;
		endcase
	endtask

	// Drop valid and wait for every pending verdict, then cover the latency.
	task automatic drain_results();
		int waited;
		in_valid <= 1'b0;
		waited = 0;
		while (pending_verdicts.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		if (pending_verdicts.size() != 0) begin
			flag_error($sformatf("%0d results never arrived", pending_verdicts.size()));
			pending_verdicts.delete();
		end
		repeat (4) @(posedge clk);
	endtask

	// Build a frame under the current start bytes and send its first cut
	// bytes (all of it when cut is zero); corrupt flips one bit of the CRC.
	task automatic send_frame(input int src_len, input int pay_len, input logic [7:0] cmd_b,
			input bit corrupt, input int cut);
		logic [7:0]       frame[$];
		logic [CRC_W-1:0] crc;
		int               n;
		frame = {shadow_cfg.start_one, shadow_cfg.start_two};
		repeat (3) frame.push_back(8'($urandom));
		frame.push_back(8'(src_len));
		repeat (src_len) frame.push_back(8'($urandom));
		frame.push_back(cmd_b);
		frame.push_back(8'(pay_len >> 8));
		frame.push_back(8'(pay_len));
		repeat (pay_len) frame.push_back(8'($urandom));
		crc = CRC_INIT;
		for (int i = 2; i < frame.size(); i++) crc = x25_update(crc, frame[i]);
		crc = crc ^ CRC_XOR;
		if (corrupt) crc = crc ^ (16'd1 << $urandom_range(15));
		frame.push_back(crc[15:8]);
		frame.push_back(crc[7:0]);
		n = (cut == 0) ? frame.size() : cut;
		for (int i = 0; i < n; i++) send_byte(frame[i]);
	endtask

	// Mostly well-formed frames with random content; the rest bad or noise.
	task automatic send_random_frame();
		int pick, max_s, max_p, s, p, hi;
		max_s = shadow_cfg.max_src_len;
		max_p = shadow_cfg.max_pay_len;
		pick  = $urandom_range(99);
		s = ($urandom_range(9) == 0) ? $urandom_range(max_s) : $urandom_range(max_s < 8 ? max_s : 8);
		p = ($urandom_range(9) == 0) ? $urandom_range(max_p < 300 ? max_p : 300)
			: $urandom_range(max_p < 16 ? max_p : 16);
		if (pick < 70) begin
			send_frame(s, p, 8'($urandom), 1'b0, 0);
		end else if (pick < 77) begin
			send_frame(s, p, 8'($urandom), 1'b1, 0);
		end else if (pick < 83 && max_s < 255) begin
			// stop right after the oversized source length byte
			send_frame($urandom_range(max_s + 1, 255), 0, 8'($urandom), 1'b0, 6);
		end else if (pick < 89 && max_p < 65535) begin
			// stop right after the oversized payload length low byte
			hi = (max_p + 300 > 65535) ? 65535 : max_p + 300;
			send_frame(s, $urandom_range(max_p + 1, hi), 8'($urandom), 1'b0, 9 + s);
		end else if (pick < 95) begin
			repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
		end else begin
			// broken frame: the next one lands in its middle
			send_frame(s, p, 8'($urandom), 1'b0, $urandom_range(1, 10 + s + p));
		end
	endtask

	// Reset register values: each way a frame can go bad, plus a minimal frame.
	task automatic test_reset_defaults();
		drain_results();
		send_byte(8'h00);                              // first start byte wrong
		send_byte(shadow_cfg.start_one);
		send_byte(8'hFF);                              // second start byte wrong
		send_byte(shadow_cfg.start_one);
		send_byte(shadow_cfg.start_two);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'h5A);
		send_byte(shadow_cfg.max_src_len + 8'd1);      // source length over limit
		send_frame(0, 0, 8'hFF, 1'b0, 0);              // empty address and payload
		send_frame(0, 0, 8'h00, 1'b1, 0);              // CRC mismatch
		send_frame(0, int'(shadow_cfg.max_pay_len) + 1, 8'h00, 1'b0, 9);
		drain_results();
	endtask

	// A limit written between bytes of one frame applies to the next byte.
	task automatic test_midframe_limit();
		drain_results();
		send_byte(shadow_cfg.start_one);
		send_byte(shadow_cfg.start_two);
		send_byte(8'h01);
		send_byte(8'h02);
		send_byte(8'h03);
		drain_results();
		write_reg(REG_MAX_SRC_LEN, {8'($urandom), 8'd4});
		send_byte(8'd5);
		drain_results();
		write_reg(REG_MAX_SRC_LEN, {8'($urandom), RST_MAX_SRC_LEN});
	endtask

	// Hold the result side off while the sender keeps offering bytes, so the
	// block fills and stalls its input; the hold is counted in its own process.
	task automatic test_input_backpressure();
		drain_results();
		hold_off <= 1'b1;
		fork
			begin
				repeat (80) @(posedge clk);
				hold_off <= 1'b0;
			end
		join_none
		send_frame(6, 24, 8'h3C, 1'b0, 0);
		drain_results();
	endtask

	// Random traffic across several register settings, extremes included.
	task automatic test_random_traffic();
		int goal;
		for (int ph = 0; ph < 6; ph++) begin
			drain_results();
			case (ph)
				1: begin
					write_reg(REG_START_ONE, {8'($urandom), 8'h00});
					write_reg(REG_START_TWO, {8'($urandom), 8'hFF});
					write_reg(REG_MAX_SRC_LEN, {8'($urandom), 8'd0});
					write_reg(REG_MAX_PAY_LEN, 16'd0);
				end
				2: begin
					write_reg(REG_START_ONE, {8'($urandom), 8'hFF});
					write_reg(REG_START_TWO, {8'($urandom), 8'h00});
					write_reg(REG_MAX_SRC_LEN, {8'($urandom), 8'hFF});
					write_reg(REG_MAX_PAY_LEN, 16'hFFFF);
				end
				3, 4, 5: begin
					write_reg(REG_START_ONE, 16'($urandom));
					write_reg(REG_START_TWO, 16'($urandom));
					write_reg(REG_MAX_SRC_LEN, {8'($urandom), 8'($urandom_range(0, 40))});
					write_reg(REG_MAX_PAY_LEN, $urandom_range(1) ? 16'($urandom_range(0, 64))
						: 16'($urandom));
					// indexes past the last register must leave the shadow alone
					write_reg((ph == 4) ? 8'hFF : 8'($urandom_range(4, 255)), 16'($urandom));
				end
				default: ;
			endcase
			goal = bytes_sent + 50;
			while (bytes_sent < goal) send_random_frame();
		end
		drain_results();
	endtask

	// Frame with the widest source address, sent without idling on either side.
	task automatic test_longest_frame();
		drain_results();
		idle_pct = 0;
		write_reg(REG_MAX_SRC_LEN, 16'h00FF);
		write_reg(REG_MAX_PAY_LEN, 16'hFFFF);
		send_frame(255, 8, 8'hA5, 1'b0, 0);
		drain_results();
		idle_pct = 26;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_midframe_limit();
		test_input_backpressure();
		test_random_traffic();
		test_longest_frame();
		drain_results();
		repeat (10) @(posedge clk);
		if (error_count == 0) begin
			$display("uart_frame_validator_crc16_core regression: pass");
		end else begin
			$display("uart_frame_validator_crc16_core regression: fail");
		end
		$finish;
	end

endmodule
